>>> src/tct_pkg.sv
// Package for the three-circle trilateration block.
// Holds the result status codes and the pipeline control struct.
// No dependencies.
package tct_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SINGULAR  = 2'd1,
    STATUS_SATURATED = 2'd2
  } status_e;

  // Control that travels down the pipeline next to the data.
  typedef struct packed {
    logic valid;
    logic singular;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage

>>> src/tct_in_if.sv
// Input channel: three circles, valid/ready handshake.
// Depends on nothing.
interface tct_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] first_x;
  logic signed [W-1:0] first_y;
  logic        [W-1:0] first_radius;
  logic signed [W-1:0] second_x;
  logic signed [W-1:0] second_y;
  logic        [W-1:0] second_radius;
  logic signed [W-1:0] third_x;
  logic signed [W-1:0] third_y;
  logic        [W-1:0] third_radius;

  modport source (
    output valid, first_x, first_y, first_radius, second_x, second_y, second_radius,
           third_x, third_y, third_radius,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_radius, second_x, second_y, second_radius,
           third_x, third_y, third_radius,
    output ready
  );
endinterface

>>> src/tct_out_if.sv
// Output channel: intersection point and status, valid/ready handshake.
// Depends on nothing.
interface tct_out_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic        [1:0]   status;

  modport source (output valid, point_x, point_y, status, input ready);
  modport sink   (input valid, point_x, point_y, status, output ready);
endinterface

>>> src/three_circle_trilateration.sv
// Three-circle trilateration, top level.
// Takes three circles (center and radius, raw fixed point) on in_i and returns
// their common point on out_o, solving the 2x2 system from subtracting circle
// three by Cramer's rule, quotients truncated toward zero.
// Both channels use valid/ready; a transaction happens when both are high.
// Pipeline: four front stages, one restoring-division step per stage over
// COORD_BITS + 1 quotient bits, and the output register.
// Throughput: one transaction per cycle while out_o does not stall; circles
// sets are independent.
// Status: ok, singular (collinear centers, point forced to zero) or saturated
// (a coordinate clamped to the signed range).
// A stall on out_o freezes the whole pipeline; in_i.ready drops for as long
// as the output register holds a result that is not taken. Nothing is lost
// or repeated.
// Reset clears all valid bits; the data registers are not reset.
// Depends on tct_pkg, tct_in_if, tct_out_if, tct_front, tct_div_stage.
module three_circle_trilateration #(
  parameter int COORD_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tct_in_if.sink   in_i,
  tct_out_if.source out_o
);
  localparam int N  = COORD_BITS;
  localparam int NW = 3 * N + 6;
  localparam int DW = 2 * N + 5;

  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  tct_pkg::ctl_t ctl   [0:N+1];
  logic [NW-1:0] remx  [0:N+1];
  logic [NW-1:0] remy  [0:N+1];
  logic [N:0]    qx    [0:N+1];
  logic [N:0]    qy    [0:N+1];
  logic [DW-1:0] dvs   [0:N+1];

  tct_front #(.N(N)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .x1_i    (in_i.first_x),
    .y1_i    (in_i.first_y),
    .r1_i    (in_i.first_radius),
    .x2_i    (in_i.second_x),
    .y2_i    (in_i.second_y),
    .r2_i    (in_i.second_radius),
    .x3_i    (in_i.third_x),
    .y3_i    (in_i.third_y),
    .r3_i    (in_i.third_radius),
    .ctl_o   (ctl[0]),
    .remx_o  (remx[0]),
    .remy_o  (remy[0]),
    .dvs_o   (dvs[0])
  );

  assign qx[0] = '0;
  assign qy[0] = '0;

  // quotient bit N is the overflow probe, then bits N-1 down to 0
  for (genvar i = 0; i <= N; i++) begin : g_div
    tct_div_stage #(.N(N), .K(N - i)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl[i]),
      .remx_i (remx[i]),
      .remy_i (remy[i]),
      .qx_i   (qx[i]),
      .qy_i   (qy[i]),
      .dvs_i  (dvs[i]),
      .ctl_o  (ctl[i+1]),
      .remx_o (remx[i+1]),
      .remy_o (remy[i+1]),
      .qx_o   (qx[i+1]),
      .qy_o   (qy[i+1]),
      .dvs_o  (dvs[i+1])
    );
  end

  // saturation and sign
  localparam logic [N-1:0] MaxPos = {1'b0, {(N-1){1'b1}}};
  localparam logic [N-1:0] MinNeg = {1'b1, {(N-1){1'b0}}};

  tct_pkg::ctl_t     cf;
  logic [N:0]        qfx, qfy;
  logic [N-1:0]      px_d, py_d;
  logic              satx, saty;
  tct_pkg::status_e  status_d;
  logic [N-1:0]      px_q, py_q;
  tct_pkg::status_e  status_q;

  assign cf  = ctl[N+1];
  assign qfx = qx[N+1];
  assign qfy = qy[N+1];

  always_comb begin
    if (cf.neg_x) begin
      satx = qfx[N] || (qfx[N-1:0] > MinNeg);
      px_d = satx ? MinNeg : -qfx[N-1:0];
    end else begin
      satx = qfx[N] || qfx[N-1];
      px_d = satx ? MaxPos : qfx[N-1:0];
    end
    if (cf.neg_y) begin
      saty = qfy[N] || (qfy[N-1:0] > MinNeg);
      py_d = saty ? MinNeg : -qfy[N-1:0];
    end else begin
      saty = qfy[N] || qfy[N-1];
      py_d = saty ? MaxPos : qfy[N-1:0];
    end
    if (cf.singular) begin
      px_d     = '0;
      py_d     = '0;
      status_d = tct_pkg::STATUS_SINGULAR;
    end else if (satx || saty) begin
      status_d = tct_pkg::STATUS_SATURATED;
    end else begin
      status_d = tct_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cf.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q     <= px_d;
      py_q     <= py_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.point_x = $signed(px_q);
  assign out_o.point_y = $signed(py_q);
  assign out_o.status  = status_q;
endmodule

>>> src/tct_front.sv
// Front end: differences, squares, linear system, Cramer numerators (4 stages).
// Depends on tct_pkg.
module tct_front #(
  parameter int N = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [N-1:0]     x1_i,
  input  logic signed [N-1:0]     y1_i,
  input  logic        [N-1:0]     r1_i,
  input  logic signed [N-1:0]     x2_i,
  input  logic signed [N-1:0]     y2_i,
  input  logic        [N-1:0]     r2_i,
  input  logic signed [N-1:0]     x3_i,
  input  logic signed [N-1:0]     y3_i,
  input  logic        [N-1:0]     r3_i,
  output tct_pkg::ctl_t           ctl_o,
  output logic        [3*N+5:0]   remx_o,
  output logic        [3*N+5:0]   remy_o,
  output logic        [2*N+4:0]   dvs_o
);
  localparam int CW = N + 2;     // coefficient width
  localparam int SW = 2 * N;     // square width
  localparam int EW = 2 * N + 3; // right-hand side width
  localparam int PW = 2 * N + 4; // coefficient product width
  localparam int DW = 2 * N + 5; // determinant width
  localparam int MW = 3 * N + 5; // numerator product width
  localparam int NW = 3 * N + 6; // numerator width

  // stage 1
  logic v1_q;
  logic signed [CW-1:0] a1_q, b1_q, c1_q, d1_q;
  logic        [SW-1:0] sx1_q, sy1_q, sr1_q, sx2_q, sy2_q, sr2_q, sx3_q, sy3_q, sr3_q;
  logic signed [N:0]    da_d, db_d, dc_d, dd_d;
  logic signed [SW-1:0] psx1, psy1, psx2, psy2, psx3, psy3;

  assign da_d = {x3_i[N-1], x3_i} - {x1_i[N-1], x1_i};
  assign db_d = {y3_i[N-1], y3_i} - {y1_i[N-1], y1_i};
  assign dc_d = {x3_i[N-1], x3_i} - {x2_i[N-1], x2_i};
  assign dd_d = {y3_i[N-1], y3_i} - {y2_i[N-1], y2_i};
  assign psx1 = x1_i * x1_i;
  assign psy1 = y1_i * y1_i;
  assign psx2 = x2_i * x2_i;
  assign psy2 = y2_i * y2_i;
  assign psx3 = x3_i * x3_i;
  assign psy3 = y3_i * y3_i;

  // stage 2
  logic v2_q;
  logic signed [CW-1:0] a2_q, b2_q, c2_q, d2_q;
  logic signed [EW-1:0] e1_q, e2_q;
  logic signed [PW-1:0] ad_q, bc_q;
  logic signed [EW-1:0] base_d, e1_d, e2_d;

  assign base_d = $signed({3'b0, sx3_q}) + $signed({3'b0, sy3_q}) - $signed({3'b0, sr3_q});
  assign e1_d   = base_d + $signed({3'b0, sr1_q}) - $signed({3'b0, sx1_q})
                - $signed({3'b0, sy1_q});
  assign e2_d   = base_d + $signed({3'b0, sr2_q}) - $signed({3'b0, sx2_q})
                - $signed({3'b0, sy2_q});

  // stage 3
  logic v3_q;
  logic signed [DW-1:0] det3_q;
  logic signed [MW-1:0] e1d_q, be2_q, ae2_q, e1c_q;

  // stage 4
  tct_pkg::ctl_t ctl4_q;
  logic [NW-1:0] remx4_q, remy4_q;
  logic [DW-1:0] dvs4_q;
  logic signed [NW-1:0] nx_d, ny_d;
  logic [DW-1:0] dabs_d;

  assign nx_d   = {e1d_q[MW-1], e1d_q} - {be2_q[MW-1], be2_q};
  assign ny_d   = {ae2_q[MW-1], ae2_q} - {e1c_q[MW-1], e1c_q};
  assign dabs_d = det3_q[DW-1] ? DW'(-det3_q) : DW'(det3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      ctl4_q <= '0;
    end else if (en_i) begin
      v1_q            <= valid_i;
      v2_q            <= v1_q;
      v3_q            <= v2_q;
      ctl4_q.valid    <= v3_q;
      ctl4_q.singular <= (det3_q == '0);
      ctl4_q.neg_x    <= nx_d[NW-1] ^ det3_q[DW-1];
      ctl4_q.neg_y    <= ny_d[NW-1] ^ det3_q[DW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= {da_d, 1'b0};
      b1_q  <= {db_d, 1'b0};
      c1_q  <= {dc_d, 1'b0};
      d1_q  <= {dd_d, 1'b0};
      sx1_q <= SW'(psx1);
      sy1_q <= SW'(psy1);
      sx2_q <= SW'(psx2);
      sy2_q <= SW'(psy2);
      sx3_q <= SW'(psx3);
      sy3_q <= SW'(psy3);
      sr1_q <= r1_i * r1_i;
      sr2_q <= r2_i * r2_i;
      sr3_q <= r3_i * r3_i;

      a2_q <= a1_q;
      b2_q <= b1_q;
      c2_q <= c1_q;
      d2_q <= d1_q;
      e1_q <= e1_d;
      e2_q <= e2_d;
      ad_q <= a1_q * d1_q;
      bc_q <= b1_q * c1_q;

      det3_q <= {ad_q[PW-1], ad_q} - {bc_q[PW-1], bc_q};
      e1d_q  <= e1_q * d2_q;
      be2_q  <= b2_q * e2_q;
      ae2_q  <= a2_q * e2_q;
      e1c_q  <= e1_q * c2_q;

      remx4_q <= nx_d[NW-1] ? NW'(-nx_d) : NW'(nx_d);
      remy4_q <= ny_d[NW-1] ? NW'(-ny_d) : NW'(ny_d);
      dvs4_q  <= dabs_d;
    end
  end

  assign ctl_o  = ctl4_q;
  assign remx_o = remx4_q;
  assign remy_o = remy4_q;
  assign dvs_o  = dvs4_q;
endmodule

>>> src/tct_div_stage.sv
// One restoring-division step for both quotients, registered.
// Depends on tct_pkg.
module tct_div_stage #(
  parameter int N = 16,
  parameter int K = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  tct_pkg::ctl_t         ctl_i,
  input  logic [3*N+5:0]        remx_i,
  input  logic [3*N+5:0]        remy_i,
  input  logic [N:0]            qx_i,
  input  logic [N:0]            qy_i,
  input  logic [2*N+4:0]        dvs_i,
  output tct_pkg::ctl_t         ctl_o,
  output logic [3*N+5:0]        remx_o,
  output logic [3*N+5:0]        remy_o,
  output logic [N:0]            qx_o,
  output logic [N:0]            qy_o,
  output logic [2*N+4:0]        dvs_o
);
  localparam int NW = 3 * N + 6;
  localparam int DW = 2 * N + 5;

  tct_pkg::ctl_t ctl_q;
  logic [NW-1:0] remx_q, remy_q, remx_d, remy_d, dsh;
  logic [N:0]    qx_q, qy_q, qx_d, qy_d;
  logic [DW-1:0] dvs_q;
  logic [NW:0]   candx, candy;

  always_comb begin
    dsh    = {{(NW-DW){1'b0}}, dvs_i} << K;
    candx  = {1'b0, remx_i} - {1'b0, dsh};
    candy  = {1'b0, remy_i} - {1'b0, dsh};
    remx_d = candx[NW] ? remx_i : candx[NW-1:0];
    remy_d = candy[NW] ? remy_i : candy[NW-1:0];
    qx_d   = qx_i;
    qy_d   = qy_i;
    qx_d[K] = !candx[NW];
    qy_d[K] = !candy[NW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      remx_q <= remx_d;
      remy_q <= remy_d;
      qx_q   <= qx_d;
      qy_q   <= qy_d;
      dvs_q  <= dvs_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign remx_o = remx_q;
  assign remy_o = remy_q;
  assign qx_o   = qx_q;
  assign qy_o   = qy_q;
  assign dvs_o  = dvs_q;
endmodule
